### src/pulse_counter_with_index_capture_top_assert.svh
// Assertion macros shared by the pulse counter RTL.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef PULSE_COUNTER_WITH_INDEX_CAPTURE_TOP_ASSERT_SVH
`define PULSE_COUNTER_WITH_INDEX_CAPTURE_TOP_ASSERT_SVH

// Same-cycle implication.
`define PCIC_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("pulse counter check failed");

// Next-cycle implication.
`define PCIC_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("pulse counter check failed");

`endif

### src/pcic_pkg.sv
package pcic_pkg;

    localparam int NUM_CH   = 8;
    localparam int CH_W     = 3;
    localparam int ARITH_W  = 128;
    localparam int CNT_W    = 7;

    localparam logic [31:0] NS_PER_S      = 32'd1000000000;
    localparam logic [31:0] SCALE_RESET   = 32'd65536;
    localparam logic [29:0] PERIOD_RESET  = 30'd1000000;
    localparam logic [63:0] RECIP_ONE     = 64'h0000_0001_0000_0000;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(31);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(127);

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } arith_op_t;

    typedef struct packed {
        logic               start;
        arith_op_t          op;
        logic [ARITH_W-1:0] opa;
        logic [31:0]        opb;
    } arith_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [ARITH_W-1:0] result;
    } arith_rsp_t;

    typedef struct packed {
        logic [31:0] pulse_total;
        logic [31:0] index_base;
        logic [31:0] prev_capture;
        logic        prev_a;
        logic        prev_z;
        logic        armed;
        logic        en_flag;
    } chan_state_t;

    localparam int STATE_W = $bits(chan_state_t);

    // Clamp a 128-bit magnitude to signed 64 bits and apply the sign.
    function automatic logic [63:0] sat64(input logic [127:0] v, input logic neg);
        logic [63:0] lim;
        logic [63:0] mag;
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (v[127:64] != 64'd0) begin
            mag = lim;
        end else if (v[63:0] > lim) begin
            mag = lim;
        end else begin
            mag = v[63:0];
        end
        return neg ? (64'd0 - mag) : mag;
    endfunction

endpackage

### src/pcic_state_ram.sv
module pcic_state_ram import pcic_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CH_W-1:0]   rd_addr,
    output chan_state_t       rd_data,
    input  logic              wr_en,
    input  logic [CH_W-1:0]   wr_addr,
    input  chan_state_t       wr_data
);

    chan_state_t       mem [NUM_CH];
    logic [NUM_CH-1:0] valid_reg;
    chan_state_t       rd_data_reg;
    logic              rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // An entry never written since reset reads as all zeros.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

### src/pcic_arith.sv
module pcic_arith import pcic_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    arith_op_t          op_reg;
    logic [ARITH_W-1:0] acc_reg;
    logic [ARITH_W-1:0] aux_reg;
    logic [31:0]        b_reg;
    logic [31:0]        rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [32:0] trial;
    logic        ge;

    assign trial = {rem_reg, acc_reg[ARITH_W-1]};
    assign ge    = trial >= {1'b0, b_reg};

    // Shift-add multiply, one multiplier bit per cycle; restoring divide,
    // one quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                op_reg   <= req.op;
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                b_reg    <= req.opb;
                rem_reg  <= '0;
                if (req.op == OP_MUL) begin
                    acc_reg <= '0;
                    aux_reg <= req.opa;
                end else begin
                    acc_reg <= req.opa;
                    aux_reg <= '0;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (op_reg == OP_MUL) begin
                    if (b_reg[0]) begin
                        acc_reg <= acc_reg + aux_reg;
                    end
                    aux_reg <= {aux_reg[ARITH_W-2:0], 1'b0};
                    b_reg   <= {1'b0, b_reg[31:1]};
                    if (cnt_reg == MUL_LAST) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end else begin
                    rem_reg <= ge ? 32'(trial - {1'b0, b_reg}) : trial[31:0];
                    acc_reg <= {acc_reg[ARITH_W-2:0], ge};
                    if (cnt_reg == DIV_LAST) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

### src/pulse_counter_with_index_capture_top.sv
// Channel   | Direction | Contents
// s_*       | in        | tick or capture request: pulse levels, resets, arming
// m_*       | out       | one report per channel after a capture request
// cfg_*     | in        | register writes: 0 = position scale, 1 = capture period
//
// A tick request visits each channel in turn (read, then write back).
// A capture request runs, per channel, three 32-step multiplies and one 128-step
// divide on the shared serial arithmetic unit.
// A change of position scale to a nonzero value adds a reciprocal divide.
// Reset is synchronous and active low; channel state reads as zero until written.
// A new request is taken only when the previous one is finished; a stalled
// report holds the last result while the unit prepares the next one.
`include "pulse_counter_with_index_capture_top_assert.svh"

module pulse_counter_with_index_capture_top import pcic_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // phase_a, phase_z, reset_request, arm_index
    input  logic         s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // count, raw_total, position, velocity,
                                    // index_enable, zero fill
    output logic [2:0]   m_tuser,   // channel
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_RD,
        ST_EXEC,
        ST_GO,
        ST_WAIT,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        J_SCALE,
        J_POS,
        J_VM1,
        J_VM2,
        J_VDIV
    } job_t;

    localparam logic CFG_SCALE  = 1'b0;
    localparam logic CFG_PERIOD = 1'b1;

    state_t            state_reg;
    job_t              job_reg;
    logic              action_reg;
    logic [7:0]        pa_reg, pz_reg, rst_reg, arm_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [31:0]       scale_reg, seen_reg;
    logic [29:0]       period_reg;
    logic [63:0]       rec_reg;
    logic [31:0]       cnt_reg, delta_reg, total_reg;
    logic              ie_reg;
    logic [127:0]      prod_reg;
    logic [63:0]       pos_reg;
    logic              m_tvalid_reg, m_tlast_reg;
    logic [199:0]      m_tdata_reg;
    logic [2:0]        m_tuser_reg;

    chan_state_t rd_data, wr_data;
    logic        wr_en;
    arith_req_t  arith_req;
    arith_rsp_t  arith_rsp;

    logic        last_ch;
    logic        rec_neg;
    logic [63:0] rec_mag;
    logic        scale_neg;
    logic [31:0] scale_mag;
    logic        cnt_neg, delta_neg;
    logic [31:0] cnt_mag, delta_mag;
    logic [31:0] period_eff;
    chan_state_t tick_st, cap_st;
    logic [31:0] cap_total, cap_cnt, cap_delta;

    assign last_ch    = (ch_reg == CH_W'(NUM_CH - 1));
    assign rec_neg    = rec_reg[63];
    assign rec_mag    = rec_neg ? (64'd0 - rec_reg) : rec_reg;
    assign scale_neg  = seen_reg[31];
    assign scale_mag  = scale_neg ? (32'd0 - seen_reg) : seen_reg;
    assign cnt_neg    = cnt_reg[31];
    assign cnt_mag    = cnt_neg ? (32'd0 - cnt_reg) : cnt_reg;
    assign delta_neg  = delta_reg[31];
    assign delta_mag  = delta_neg ? (32'd0 - delta_reg) : delta_reg;
    assign period_eff = (period_reg == 30'd0) ? 32'd1 : {2'b00, period_reg};

    // Tick update of one channel: count rising A, latch base on armed rising Z.
    always_comb begin
        tick_st = rd_data;
        if (!rd_data.prev_a && pa_reg[ch_reg]) begin
            tick_st.pulse_total = rd_data.pulse_total + 32'd1;
        end
        tick_st.prev_a = pa_reg[ch_reg];
        if (rd_data.armed && !rd_data.prev_z && pz_reg[ch_reg]) begin
            tick_st.index_base = tick_st.pulse_total;
            tick_st.en_flag    = 1'b0;
        end
        tick_st.prev_z = pz_reg[ch_reg];
    end

    // Capture update: arming first, then the counter reset, then the report
    // values; the index latch takes the enable flag afterwards.
    always_comb begin
        cap_st = rd_data;
        if (arm_reg[ch_reg]) begin
            cap_st.en_flag = 1'b1;
        end
        if (rst_reg[ch_reg]) begin
            cap_st.pulse_total  = '0;
            cap_st.index_base   = '0;
            cap_st.prev_capture = '0;
        end
        cap_total = cap_st.pulse_total;
        cap_cnt   = cap_total - cap_st.index_base;
        cap_delta = cap_total - cap_st.prev_capture;
        cap_st.prev_capture = cap_total;
        cap_st.armed        = cap_st.en_flag;
    end

    assign wr_en   = (state_reg == ST_EXEC);
    assign wr_data = action_reg ? cap_st : tick_st;

    pcic_state_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (ch_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (ch_reg),
        .wr_data (wr_data)
    );

    // Operands for the serial arithmetic unit, chosen by the pending job.
    always_comb begin
        arith_req.start = (state_reg == ST_GO);
        arith_req.op    = OP_MUL;
        arith_req.opa   = {64'd0, rec_mag};
        arith_req.opb   = cnt_mag;
        case (job_reg)
            J_SCALE: begin
                arith_req.op  = OP_DIV;
                arith_req.opa = 128'({1'b1, 48'd0} + {17'd0, scale_mag[31:1]});
                arith_req.opb = scale_mag;
            end
            J_POS: begin
                arith_req.opb = cnt_mag;
            end
            J_VM1: begin
                arith_req.opb = delta_mag;
            end
            J_VM2: begin
                arith_req.opa = prod_reg;
                arith_req.opb = NS_PER_S;
            end
            J_VDIV: begin
                arith_req.op  = OP_DIV;
                arith_req.opa = prod_reg;
                arith_req.opb = period_eff;
            end
            default: begin
                arith_req.opb = cnt_mag;
            end
        endcase
    end

    pcic_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (arith_req),
        .rsp     (arith_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            job_reg      <= J_POS;
            ch_reg       <= '0;
            scale_reg    <= SCALE_RESET;
            period_reg   <= PERIOD_RESET;
            seen_reg     <= SCALE_RESET;
            rec_reg      <= RECIP_ONE;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_SCALE:  scale_reg  <= cfg_wdata;
                    CFG_PERIOD: period_reg <= cfg_wdata[29:0];
                    default:    scale_reg  <= scale_reg;
                endcase
            end
            // In the emit state the output register is handled below.
            if (m_tvalid_reg && m_tready && state_reg != ST_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        action_reg <= s_tuser;
                        pa_reg     <= s_tdata[7:0];
                        pz_reg     <= s_tdata[15:8];
                        rst_reg    <= s_tdata[23:16];
                        arm_reg    <= s_tdata[31:24];
                        ch_reg     <= '0;
                        state_reg  <= s_tuser ? ST_SCALE : ST_RD;
                    end
                end
                ST_SCALE: begin
                    if (scale_reg != seen_reg) begin
                        seen_reg <= scale_reg;
                        if (scale_reg == 32'd0) begin
                            rec_reg   <= RECIP_ONE;
                            state_reg <= ST_RD;
                        end else begin
                            job_reg   <= J_SCALE;
                            state_reg <= ST_GO;
                        end
                    end else begin
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (action_reg) begin
                        total_reg <= cap_total;
                        cnt_reg   <= cap_cnt;
                        delta_reg <= cap_delta;
                        ie_reg    <= cap_st.en_flag;
                        job_reg   <= J_POS;
                        state_reg <= ST_GO;
                    end else if (last_ch) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        ch_reg    <= ch_reg + CH_W'(1);
                        state_reg <= ST_RD;
                    end
                end
                ST_GO: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (arith_rsp.done) begin
                        case (job_reg)
                            J_SCALE: begin
                                rec_reg   <= scale_neg ? (64'd0 - arith_rsp.result[63:0])
                                                       : arith_rsp.result[63:0];
                                state_reg <= ST_RD;
                            end
                            J_POS: begin
                                pos_reg   <= sat64(arith_rsp.result, cnt_neg ^ rec_neg);
                                job_reg   <= J_VM1;
                                state_reg <= ST_GO;
                            end
                            J_VM1: begin
                                prod_reg  <= arith_rsp.result;
                                job_reg   <= J_VM2;
                                state_reg <= ST_GO;
                            end
                            J_VM2: begin
                                prod_reg  <= arith_rsp.result;
                                job_reg   <= J_VDIV;
                                state_reg <= ST_GO;
                            end
                            J_VDIV: begin
                                prod_reg  <= arith_rsp.result;
                                state_reg <= ST_EMIT;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= last_ch;
                        m_tuser_reg  <= ch_reg;
                        m_tdata_reg  <= {7'd0, ie_reg,
                                         sat64(prod_reg, delta_neg ^ rec_neg),
                                         pos_reg, total_reg, cnt_reg};
                        if (last_ch) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            ch_reg    <= ch_reg + CH_W'(1);
                            state_reg <= ST_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    `PCIC_ASSERT_IMP(a_idle_arith_quiet, state_reg == ST_IDLE, !arith_rsp.busy)
    `PCIC_ASSERT_IMP(a_last_is_top_channel, m_tvalid && m_tlast, m_tuser == CH_W'(NUM_CH - 1))
    `PCIC_ASSERT_NXT(a_request_starts_work, s_tvalid && s_tready, state_reg != ST_IDLE)

endmodule
